FILE: src/psfp_pkg.sv
// shared constants and types for the particle sensor frame parser
`default_nettype none

package psfp_pkg;

  // frame layout
  localparam int FRAME_BYTES     = 32;
  localparam int NUM_WORDS       = 12;
  localparam int FIRST_WORD_BYTE = 4;
  localparam int POS_W           = $clog2(FRAME_BYTES);
  localparam int IDX_W           = 4;

  localparam logic [7:0]       START_BYTE   = 8'h42;
  localparam logic [POS_W-1:0] POS_HUNT     = '0;
  localparam logic [POS_W-1:0] POS_WORD_LO  = POS_W'(FIRST_WORD_BYTE);
  localparam logic [POS_W-1:0] POS_WORD_HI  = POS_W'(FIRST_WORD_BYTE + 2 * NUM_WORDS);
  localparam logic [POS_W-1:0] POS_CHECK_HI = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_CHECK_LO = POS_W'(FRAME_BYTES - 1);

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SUM = 1'b1;

  // frame queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one finished frame handed from front to back
  typedef struct packed {
    logic                        sum_ok;
    logic [NUM_WORDS-1:0][15:0]  words;
  } frame_t;

  // queue side status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: src/psfp_front.sv
// byte parser: hunts for start, sums, collects words, checks the frame
`default_nettype none

module psfp_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_stall,
  input  wire logic [7:0]            rx_byte,
  input  wire psfp_pkg::queue_status_t q_status,
  output logic                       push,
  output psfp_pkg::frame_t           push_frame
);

  logic [psfp_pkg::POS_W-1:0]                 pos;
  logic [psfp_pkg::POS_W-1:0]                 pos_next;
  logic [15:0]                                sum;
  logic [15:0]                                sum_next;
  logic [7:0]                                 check_hi;
  logic [7:0]                                 word_hi;
  logic [psfp_pkg::NUM_WORDS-1:0][15:0]       words;
  logic                                       accept;
  logic                                       in_words;
  logic [psfp_pkg::POS_W-1:0]                 word_off;

  // only the closing byte needs room in the queue
  assign byte_stall = (pos == psfp_pkg::POS_CHECK_LO) && q_status.full;
  assign accept     = byte_valid && !byte_stall;

  assign word_off = pos - psfp_pkg::POS_WORD_LO;
  assign in_words = (pos >= psfp_pkg::POS_WORD_LO) && (pos < psfp_pkg::POS_WORD_HI);

  // position and running sum
  always_comb begin
    pos_next = pos;
    sum_next = sum;
    if (pos == psfp_pkg::POS_HUNT) begin
      if (rx_byte == psfp_pkg::START_BYTE) begin
        pos_next = pos + 1'b1;
        sum_next = 16'(rx_byte);
      end
    end else if (pos == psfp_pkg::POS_CHECK_LO) begin
      pos_next = psfp_pkg::POS_HUNT;
      sum_next = '0;
    end else begin
      pos_next = pos + 1'b1;
      if (pos < psfp_pkg::POS_CHECK_HI) begin
        sum_next = sum + 16'(rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= psfp_pkg::POS_HUNT;
      sum <= '0;
    end else if (accept) begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  // word collection, shifting in at the top so word 0 ends at the bottom
  always_ff @(posedge clk) begin
    if (accept && in_words) begin
      if (!word_off[0]) begin
        word_hi <= rx_byte;
      end else begin
        words <= {{word_hi, rx_byte}, words[psfp_pkg::NUM_WORDS-1:1]};
      end
    end
    if (accept && pos == psfp_pkg::POS_CHECK_HI) begin
      check_hi <= rx_byte;
    end
  end

  // frame close: push the checksum verdict with the words
  assign push             = accept && (pos == psfp_pkg::POS_CHECK_LO);
  assign push_frame.sum_ok = ({check_hi, rx_byte} == sum);
  assign push_frame.words  = words;

endmodule

`default_nettype wire

FILE: src/psfp_queue.sv
// short queue of finished frames between parser and emitter
`default_nettype none

module psfp_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire psfp_pkg::frame_t       push_frame,
  input  wire logic                   pop,
  output psfp_pkg::frame_t            pop_frame,
  output psfp_pkg::queue_status_t     q_status
);

  psfp_pkg::frame_t                   entries [psfp_pkg::QUEUE_DEPTH];
  logic [psfp_pkg::QPTR_W-1:0]        wr_ptr;
  logic [psfp_pkg::QPTR_W-1:0]        rd_ptr;
  logic [psfp_pkg::QCNT_W-1:0]        count;

  assign q_status.full      = (count == psfp_pkg::QCNT_W'(psfp_pkg::QUEUE_DEPTH));
  assign q_status.not_empty = (count != '0);
  assign pop_frame          = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no write into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_status.full)
    else $error("frame pushed into full queue");

  // no read from an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> q_status.not_empty)
    else $error("frame popped from empty queue");

  // fill count rises on a push without a pop
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("fill count missed a push");

  assert property (@(posedge clk) disable iff (rst)
    count <= psfp_pkg::QCNT_W'(psfp_pkg::QUEUE_DEPTH))
    else $error("fill count beyond depth");

endmodule

`default_nettype wire

FILE: src/psfp_back.sv
// result emitter: turns a queued frame into result transactions
`default_nettype none

module psfp_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire psfp_pkg::queue_status_t q_status,
  input  wire psfp_pkg::frame_t       pop_frame,
  output logic                        pop,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic                        status,
  output logic [3:0]                  value_index,
  output logic [15:0]                 value,
  output logic                        last
);

  logic                                   busy;
  logic                                   sum_ok;
  logic [psfp_pkg::IDX_W-1:0]             idx;
  logic [psfp_pkg::NUM_WORDS-1:0][15:0]   words;
  logic                                   out_free;
  logic                                   emit;
  logic                                   emit_last;

  assign out_free  = !result_valid || !result_stall;
  assign pop       = !busy && q_status.not_empty;
  assign emit      = busy && out_free;
  assign emit_last = !sum_ok || (idx == psfp_pkg::IDX_W'(psfp_pkg::NUM_WORDS - 1));

  // frame sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (emit && emit_last) begin
      busy <= 1'b0;
    end
  end

  // working copy of the frame, shifted one word per result
  always_ff @(posedge clk) begin
    if (pop) begin
      sum_ok <= pop_frame.sum_ok;
      words  <= pop_frame.words;
      idx    <= '0;
    end else if (emit) begin
      words <= {16'h0000, words[psfp_pkg::NUM_WORDS-1:1]};
      idx   <= idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= sum_ok ? psfp_pkg::STATUS_OK : psfp_pkg::STATUS_BAD_SUM;
      value_index <= sum_ok ? idx : '0;
      value       <= sum_ok ? words[0] : '0;
      last        <= emit_last;
    end
  end

  // a bad frame gives a single result marked last
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == psfp_pkg::STATUS_BAD_SUM) |-> last)
    else $error("checksum error result not marked last");

  // no new frame while one is still being emitted
  assert property (@(posedge clk) disable iff (rst) busy |-> !pop)
    else $error("frame popped while busy");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(value) && $stable(last)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: src/particle_sensor_frame_parser.sv
// top level of the particle sensor frame parser
//
//   channel   direction   handshake                    payload
//   bytes     in          byte_valid / byte_stall      rx_byte
//   results   out         result_valid / result_stall  status, value_index, value, last
//
// one byte is taken each cycle; the parser only stalls on a frame's closing byte
// when both frame queue entries are still waiting.
// a good frame leaves the emitter as 12 results, a bad one as 1.
// the two-entry frame queue lets a new frame be parsed while the previous one drains.
// rst is synchronous and clears position, sum, queue pointers and output valid.
// result_stall holds the output register and the emitter; the parser keeps taking
// bytes until the queue fills.
`default_nettype none

module particle_sensor_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             status,
  output logic [3:0]       value_index,
  output logic [15:0]      value,
  output logic             last
);

  logic                     push;
  logic                     pop;
  psfp_pkg::frame_t         push_frame;
  psfp_pkg::frame_t         pop_frame;
  psfp_pkg::queue_status_t  q_status;

  // byte parser
  psfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .q_status   (q_status),
    .push       (push),
    .push_frame (push_frame)
  );

  // frame queue
  psfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .q_status   (q_status)
  );

  // result emitter
  psfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop_frame    (pop_frame),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .value_index  (value_index),
    .value        (value),
    .last         (last)
  );

endmodule

`default_nettype wire
